// File: src/assert_macros.svh
// assertion macros used by the top level of the stream hasher
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/sha_pkg.sv
// types, constants and round functions of the sha-256 stream hasher
`default_nettype none

package sha_pkg;

    // eight 32-bit words, word 0 in the lowest bits
    typedef logic [7:0][31:0] word8_t;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [5:0] LAST_BYTE  = 6'd63;

    localparam word8_t SHA_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    // sequencer states of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD2,
        ST_EMIT
    } state_t;

    // control from the sequencer to the round unit
    typedef struct packed {
        logic        start;
        logic [31:0] w_word;
    } sha_ctrl_t;

    // status from the round unit
    typedef struct packed {
        logic busy;
        logic last;
    } sha_stat_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // round constant table
    function automatic logic [31:0] round_k(input logic [5:0] idx);
        case (idx)
            6'd0:  round_k = 32'h428a2f98;
            6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;
            6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;
            6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;
            6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;
            6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;
            6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;
            6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;
            6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;
            6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;
            6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;
            6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;
            6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;
            6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;
            6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;
            6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;
            6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;
            6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;
            6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;
            6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;
            6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;
            6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;
            6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;
            6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;
            6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;
            6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;
            6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;
            6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;
            6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;
            6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;
            6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;
            6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;
            6'd63: round_k = 32'hc67178f2;
            default: round_k = 32'h0;
        endcase
    endfunction

endpackage

`default_nettype wire

// File: src/sha_round_unit.sv
// sha-256 round unit: working variables, round counter, one round per cycle
`default_nettype none

module sha_round_unit
    import sha_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire sha_ctrl_t ctrl,
    input  wire word8_t    chain_in,
    output word8_t         work_out,
    output sha_stat_t      status
);

    word8_t     work_reg, work_next;
    logic [5:0] round_reg, round_next;
    logic       busy_reg, busy_next;

    logic [31:0] t1, t2, ch, maj;

    // one compression round on the working variables, or the load of the chaining words on start
    always_comb begin
        ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2]) ^
              (work_reg[1] & work_reg[2]);
        t1  = work_reg[7] + big_sigma1(work_reg[4]) + ch + round_k(round_reg) + ctrl.w_word;
        t2  = big_sigma0(work_reg[0]) + maj;

        work_next  = work_reg;
        round_next = round_reg;
        busy_next  = busy_reg;
        if (ctrl.start) begin
            work_next  = chain_in;
            round_next = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            work_next[7] = work_reg[6];
            work_next[6] = work_reg[5];
            work_next[5] = work_reg[4];
            work_next[4] = work_reg[3] + t1;
            work_next[3] = work_reg[2];
            work_next[2] = work_reg[1];
            work_next[1] = work_reg[0];
            work_next[0] = t1 + t2;
            round_next   = round_reg + 6'd1;
            if (round_reg == LAST_ROUND) begin
                busy_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            round_reg <= '0;
            busy_reg  <= 1'b0;
        end else begin
            round_reg <= round_next;
            busy_reg  <= busy_next;
        end
    end

    // working variables
    always_ff @(posedge aclk) begin
        work_reg <= work_next;
    end

    assign work_out    = work_reg;
    assign status.busy = busy_reg;
    assign status.last = busy_reg && (round_reg == LAST_ROUND);

endmodule

`default_nettype wire

// File: src/sha256_stream_hasher.sv
// top level of the sha-256 stream hasher: byte gathering, padding, schedule, sequencer
`default_nettype none
`include "assert_macros.svh"

// SHA-256 of a byte stream. Each input word (s_tuser = 0) carries one message byte in
// s_tdata; a word with s_tuser = 1 finishes the message, and the 256-bit digest comes
// out as one output word, digest word 0 (most significant) in m_tdata[31:0]. After the
// digest the chaining state returns to the initial values for the next message. The
// 64th byte of a block starts the compression, which runs one round per cycle on a
// single round unit; the rounds and the chaining add finish before the next byte is
// taken. A finish pads the buffered bytes and compresses the block, and a second
// length block follows when 56 or more bytes are buffered; the digest is then loaded
// into the output register. Data bytes of the next message are taken while the
// digest still waits on m_tready.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // data_byte
    input  wire logic         s_tuser,   // kind
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [255:0]      m_tdata    // digest_word_0 .. digest_word_7
);

    localparam int TOTAL_W = 61;

    state_t state_reg, state_next;

    logic [5:0]         fill_reg, fill_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               final_reg, final_next;
    logic               second_reg, second_next;
    logic               out_valid_reg, out_valid_next;
    word8_t             chain_reg, chain_next;
    word8_t             out_reg;
    logic [31:0]        w_reg [16];
    logic [31:0]        w_next [16];

    logic        accept, take_byte, take_finish;
    logic        core_start, shift_en, add_en, pad2_load, out_load;
    logic        overflow;
    logic [63:0] len_bits;
    logic [31:0] w_new;

    sha_ctrl_t ctrl;
    sha_stat_t core_status;
    word8_t    work_words;

    assign accept      = s_tvalid && s_tready;
    assign take_byte   = accept && !s_tuser;
    assign take_finish = accept && s_tuser;
    assign overflow    = fill_reg >= LEN_OFFSET;
    assign len_bits    = {total_reg, 3'b000};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take_finish || (take_byte && fill_reg == LAST_BYTE)) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (core_status.last) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                if (!final_reg) begin
                    state_next = ST_IDLE;
                end else if (second_reg) begin
                    state_next = ST_PAD2;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_PAD2: begin
                state_next = ST_ROUND;
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready   = 1'b0;
        core_start = 1'b0;
        shift_en   = 1'b0;
        add_en     = 1'b0;
        pad2_load  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                core_start = take_finish || (take_byte && fill_reg == LAST_BYTE);
            end
            ST_ROUND: begin
                shift_en = 1'b1;
            end
            ST_ADD: begin
                add_en = 1'b1;
            end
            ST_PAD2: begin
                pad2_load  = 1'b1;
                core_start = 1'b1;
            end
            ST_EMIT: begin
                out_load = !out_valid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // message schedule word for the next window slot
    assign w_new = w_reg[0] + small_sigma0(w_reg[1]) + w_reg[9] + small_sigma1(w_reg[14]);

    // block window: byte writes, padding, length block and schedule shift
    always_comb begin
        w_next = w_reg;
        if (take_byte) begin
            case (fill_reg[1:0])
                2'd0:    w_next[fill_reg[5:2]][31:24] = s_tdata;
                2'd1:    w_next[fill_reg[5:2]][23:16] = s_tdata;
                2'd2:    w_next[fill_reg[5:2]][15:8]  = s_tdata;
                default: w_next[fill_reg[5:2]][7:0]   = s_tdata;
            endcase
        end else if (take_finish) begin
            for (int j = 0; j < 16; j++) begin
                for (int l = 0; l < 4; l++) begin
                    if (6'(4 * j + l) == fill_reg) begin
                        w_next[j][31 - 8 * l -: 8] = PAD_MARK;
                    end else if (6'(4 * j + l) > fill_reg) begin
                        w_next[j][31 - 8 * l -: 8] = 8'h00;
                    end
                end
            end
            if (!overflow) begin
                w_next[14] = len_bits[63:32];
                w_next[15] = len_bits[31:0];
            end
        end else if (pad2_load) begin
            for (int j = 0; j < 14; j++) begin
                w_next[j] = '0;
            end
            w_next[14] = len_bits[63:32];
            w_next[15] = len_bits[31:0];
        end else if (shift_en) begin
            for (int j = 0; j < 15; j++) begin
                w_next[j] = w_reg[j + 1];
            end
            w_next[15] = w_new;
        end
    end

    // counters, chaining words and output flag
    always_comb begin
        fill_next      = fill_reg;
        total_next     = total_reg;
        final_next     = final_reg;
        second_next    = second_reg;
        chain_next     = chain_reg;
        out_valid_next = out_valid_reg;
        if (m_tvalid && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (take_byte) begin
            fill_next  = fill_reg + 6'd1;
            total_next = total_reg + TOTAL_W'(1);
        end
        if (take_finish) begin
            final_next  = 1'b1;
            second_next = overflow;
        end
        if (pad2_load) begin
            second_next = 1'b0;
        end
        if (add_en) begin
            for (int i = 0; i < 8; i++) begin
                chain_next[i] = chain_reg[i] + work_words[i];
            end
        end
        if (out_load) begin
            out_valid_next = 1'b1;
            chain_next     = SHA_INIT;
            fill_next      = '0;
            total_next     = '0;
            final_next     = 1'b0;
            second_next    = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            total_reg     <= '0;
            final_reg     <= 1'b0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            chain_reg     <= SHA_INIT;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            final_reg     <= final_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
            chain_reg     <= chain_next;
        end
    end

    // block window and digest register
    always_ff @(posedge aclk) begin
        w_reg <= w_next;
        if (out_load) begin
            out_reg <= chain_reg;
        end
    end

    assign ctrl.start  = core_start;
    assign ctrl.w_word = w_reg[0];

    sha_round_unit u_round (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .chain_in (chain_reg),
        .work_out (work_words),
        .status   (core_status)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // checks
    `ASSERT_PROP(a_ready_core_idle, aclk, aresetn, s_tready |-> !core_status.busy,
        "input taken while the round unit is busy")
    `ASSERT_NEXT(a_full_block_starts, aclk, aresetn, take_byte && fill_reg == LAST_BYTE,
        state_reg == ST_ROUND && core_status.busy && fill_reg == 6'd0,
        "full block did not start compression")
    `ASSERT_NEXT(a_emit_clears, aclk, aresetn, out_load,
        m_tvalid && fill_reg == 6'd0 && total_reg == '0 && state_reg == ST_IDLE,
        "digest load did not restart the message state")
    `ASSERT_PROP(a_round_in_round_state, aclk, aresetn,
        core_status.busy |-> (state_reg == ST_ROUND),
        "round unit busy outside the round state")

endmodule

`default_nettype wire
